// ===== design/greedy_voxel_face_mesher_core_macros.svh =====
// Assertion macros shared by the mesher checkers.
// No dependencies; included by the checker file.
`ifndef GREEDY_VOXEL_FACE_MESHER_CORE_MACROS_SVH
`define GREEDY_VOXEL_FACE_MESHER_CORE_MACROS_SVH

// Generic clocked assertion with asynchronous active-low reset disable.
`define GVFM_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Same, bound to the usual clk / rst_n names.
`define GVFM_CHECK(lbl, prop, msg) `GVFM_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

// ===== design/gvfm_pkg.sv =====
// Package for the greedy voxel face mesher: sizes, codes and channel types.
// No dependencies; used by every module of the block.
package gvfm_pkg;

    localparam int MAX_DIM     = 32;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int CNT_W       = $clog2(MAX_DIM + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int SLICE_W     = $clog2(MAX_DIM + 2);
    localparam int VOX_AW      = 3 * DIM_W;
    localparam int MASK_AW     = 2 * DIM_W;
    localparam int VOX_DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int MASK_DEPTH  = MAX_DIM * MAX_DIM;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE  = 4'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PULL  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [4:0] cell_z;
        logic [7:0] voxel_value;
    } item_t;

    typedef struct packed {
        logic       quad_valid;
        logic       sweep_done;
        logic [7:0] quad_colour;
        logic [2:0] face_dir;
        logic [5:0] base_x;
        logic [5:0] base_y;
        logic [5:0] base_z;
        logic [5:0] extent_u;
        logic [5:0] extent_v;
    } result_t;

    // Classified command handed from front to back.
    typedef struct packed {
        logic              is_pull;
        logic              in_range;
        logic [VOX_AW-1:0] vox_addr;
        logic [7:0]        value;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_BA, ST_BB, ST_BW, ST_SC_RD, ST_SC_CK,
        ST_GW_RD, ST_GW_CK, ST_GH_RD, ST_GH_CK, ST_ZAP, ST_NEXT, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE, PH_SCAN, PH_DONE
    } phase_t;

    function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] s);
        eff_size = (32'(s) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(s);
    endfunction

endpackage

// ===== design/gvfm_front.sv =====
// Front end: accepts items, classifies them and queues commands for the back end.
// Depends on gvfm_pkg.
module gvfm_front
    import gvfm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    input  status_t status,
    output logic    cmd_valid,
    input  logic    cmd_ready,
    output cmd_t    cmd
);

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              cls;
    logic              push, pop;

    // Classification: opcode and address range check.
    always_comb
    begin
        cls.is_pull  = (item.op == OP_PULL);
        cls.in_range = (32'(item.cell_x) < MAX_DIM) && (32'(item.cell_y) < MAX_DIM) &&
                       (32'(item.cell_z) < MAX_DIM);
        cls.vox_addr = {DIM_W'(item.cell_z), DIM_W'(item.cell_y), DIM_W'(item.cell_x)};
        cls.value    = item.voxel_value;
    end

    assign item_ready = (32'(count_reg) != QUEUE_DEPTH) && !status.clearing;
    assign push       = item_valid && item_ready;
    assign cmd_valid  = (count_reg != '0);
    assign pop        = cmd_valid && cmd_ready;
    assign cmd        = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== design/gvfm_back.sv =====
// Back end: voxel store, face mask, sweep sequencer, config registers, result register.
// Depends on gvfm_pkg.
module gvfm_back
    import gvfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result
);

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [1:0]             axis_reg, axis_next;
    logic [SLICE_W-1:0]     slice_reg, slice_next;
    logic [CNT_W-1:0]       cur_r_reg, cur_r_next, cur_c_reg, cur_c_next;
    logic [CNT_W-1:0]       k_reg, k_next, l_reg, l_next, w_reg, w_next, h_reg, h_next;
    logic [7:0]             colour_reg, colour_next, a_reg, a_next;
    logic                   facing_reg, facing_next;
    logic [VOX_AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [CFG_DATA_W-1:0]  size_x_reg, size_x_next, size_y_reg, size_y_next;
    logic [CFG_DATA_W-1:0]  size_z_reg, size_z_next;
    logic                   merge_reg, merge_next;
    logic                   res_valid_reg, res_valid_next;
    result_t                res_reg, res_next;

    logic [7:0]             vox_mem [VOX_DEPTH];
    logic                   vox_we;
    logic [VOX_AW-1:0]      vox_addr;
    logic [7:0]             vox_wdata, vox_rdata_reg;
    logic [8:0]             mask_mem [MASK_DEPTH];
    logic                   m_we;
    logic [MASK_AW-1:0]     m_waddr, m_raddr;
    logic [8:0]             m_wdata, m_rdata_reg;

    logic [CNT_W-1:0]       ex, ey, ez, du, dv, dd;
    logic [SUM_W-1:0]       sum_cw, sum_ck, sum_rh, sum_rl, c_inc, r_inc;
    logic [SLICE_W:0]       slice_inc;
    logic                   any_zero, out_free, jn, build_last, wrap, cfg_hit;
    logic [7:0]             b_val;

    function automatic logic [VOX_AW-1:0] cell_addr(input logic [1:0] ax,
        input logic [DIM_W-1:0] s, input logic [DIM_W-1:0] kk, input logic [DIM_W-1:0] rr);
        unique case (ax)
            2'd0:    cell_addr = {rr, kk, s};
            2'd1:    cell_addr = {kk, s, rr};
            default: cell_addr = {s, rr, kk};
        endcase
    endfunction

    // Sizes along the sweep axis and the two in-plane axes.
    always_comb
    begin
        ex = eff_size(size_x_reg);
        ey = eff_size(size_y_reg);
        ez = eff_size(size_z_reg);
        unique case (axis_reg)
            2'd0:    begin dd = ex; du = ey; dv = ez; end
            2'd1:    begin dd = ey; du = ez; dv = ex; end
            default: begin dd = ez; du = ex; dv = ey; end
        endcase
    end

    assign sum_cw     = SUM_W'(cur_c_reg) + SUM_W'(w_reg);
    assign sum_ck     = SUM_W'(cur_c_reg) + SUM_W'(k_reg);
    assign sum_rh     = SUM_W'(cur_r_reg) + SUM_W'(h_reg);
    assign sum_rl     = SUM_W'(cur_r_reg) + SUM_W'(l_reg);
    assign c_inc      = SUM_W'(cur_c_reg) + 1'b1;
    assign r_inc      = SUM_W'(cur_r_reg) + 1'b1;
    assign slice_inc  = (SLICE_W + 1)'(slice_reg) + 1'b1;
    assign wrap       = slice_inc > (SLICE_W + 1)'(dd);
    assign any_zero   = (ex == '0) || (ey == '0) || (ez == '0);
    assign out_free   = !res_valid_reg || result_ready;
    assign build_last = (c_inc >= SUM_W'(du)) && (r_inc >= SUM_W'(dv));
    assign jn         = (m_rdata_reg[7:0] != 8'd0) && (m_rdata_reg[8] == facing_reg) &&
                        (merge_reg || (m_rdata_reg[7:0] == colour_reg));
    assign cfg_hit    = cfg_valid && (cfg_index <= REG_MERGE);
    assign b_val      = (SUM_W'(slice_reg) < SUM_W'(dd)) ? vox_rdata_reg : 8'd0;

    assign cmd_ready       = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign result_valid    = res_valid_reg;
    assign result          = res_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_addr_reg == '1) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (cmd_valid && cmd.is_pull)
                begin
                    unique case (phase_reg)
                        PH_IDLE: state_next = any_zero ? ST_EMIT : ST_BA;
                        PH_SCAN: state_next = ST_SC_RD;
                        default: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_BA:     state_next = ST_BB;
            ST_BB:     state_next = ST_BW;
            ST_BW:     state_next = build_last ? ST_SC_RD : ST_BA;
            ST_SC_RD:
            begin
                if (cur_r_reg >= dv)
                    state_next = ST_NEXT;
                else if (cur_c_reg < du)
                    state_next = ST_SC_CK;
            end
            ST_SC_CK:  state_next = (m_rdata_reg[7:0] != 8'd0) ? ST_GW_RD : ST_SC_RD;
            ST_GW_RD:  state_next = (sum_cw < SUM_W'(du)) ? ST_GW_CK : ST_GH_RD;
            ST_GW_CK:  state_next = jn ? ST_GW_RD : ST_GH_RD;
            ST_GH_RD:  state_next = (sum_rh >= SUM_W'(dv)) ? ST_ZAP : ST_GH_CK;
            ST_GH_CK:  state_next = jn ? ST_GH_RD : ST_ZAP;
            ST_ZAP:
            begin
                if ((k_reg + 1'b1 == w_reg) && (l_reg + 1'b1 == h_reg))
                    state_next = ST_EMIT;
            end
            ST_NEXT:   state_next = (wrap && axis_reg == 2'd2) ? ST_EMIT : ST_BA;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        phase_next     = phase_reg;
        axis_next      = axis_reg;
        slice_next     = slice_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        k_next         = k_reg;
        l_next         = l_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        colour_next    = colour_reg;
        facing_next    = facing_reg;
        a_next         = a_reg;
        clr_addr_next  = clr_addr_reg;
        size_x_next    = size_x_reg;
        size_y_next    = size_y_reg;
        size_z_next    = size_z_reg;
        merge_next     = merge_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next       = res_reg;
        vox_we         = 1'b0;
        vox_addr       = '0;
        vox_wdata      = '0;
        m_we           = 1'b0;
        m_waddr        = '0;
        m_wdata        = '0;
        m_raddr        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                vox_we        = 1'b1;
                vox_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (cmd_valid && !cmd.is_pull)
                begin
                    vox_we     = cmd.in_range;
                    vox_addr   = cmd.vox_addr;
                    vox_wdata  = cmd.value;
                    phase_next = PH_IDLE;
                end
                else if (cmd_valid && phase_reg == PH_IDLE)
                begin
                    if (any_zero)
                        phase_next = PH_DONE;
                    else
                    begin
                        phase_next = PH_SCAN;
                        axis_next  = 2'd0;
                        slice_next = '0;
                        cur_r_next = '0;
                        cur_c_next = '0;
                    end
                end
            end
            ST_BA:
            begin
                vox_addr = cell_addr(axis_reg, DIM_W'(slice_reg - 1'b1),
                                     cur_c_reg[DIM_W-1:0], cur_r_reg[DIM_W-1:0]);
            end
            ST_BB:
            begin
                a_next   = (slice_reg != '0) ? vox_rdata_reg : 8'd0;
                vox_addr = cell_addr(axis_reg, DIM_W'(slice_reg),
                                     cur_c_reg[DIM_W-1:0], cur_r_reg[DIM_W-1:0]);
            end
            ST_BW:
            begin
                m_we    = 1'b1;
                m_waddr = {cur_r_reg[DIM_W-1:0], cur_c_reg[DIM_W-1:0]};
                if ((a_reg != 8'd0) == (b_val != 8'd0))
                    m_wdata = '0;
                else if (a_reg != 8'd0)
                    m_wdata = {1'b1, a_reg};
                else
                    m_wdata = {1'b0, b_val};
                if (build_last)
                begin
                    cur_r_next = '0;
                    cur_c_next = '0;
                end
                else if (c_inc >= SUM_W'(du))
                begin
                    cur_c_next = '0;
                    cur_r_next = CNT_W'(r_inc);
                end
                else
                    cur_c_next = CNT_W'(c_inc);
            end
            ST_SC_RD:
            begin
                if (cur_r_reg < dv && cur_c_reg >= du)
                begin
                    cur_c_next = '0;
                    cur_r_next = CNT_W'(r_inc);
                end
                m_raddr = {cur_r_reg[DIM_W-1:0], cur_c_reg[DIM_W-1:0]};
            end
            ST_SC_CK:
            begin
                if (m_rdata_reg[7:0] != 8'd0)
                begin
                    colour_next = m_rdata_reg[7:0];
                    facing_next = m_rdata_reg[8];
                    w_next      = CNT_W'(1);
                end
                else
                    cur_c_next = CNT_W'(c_inc);
            end
            ST_GW_RD:
            begin
                m_raddr = {cur_r_reg[DIM_W-1:0], sum_cw[DIM_W-1:0]};
                if (sum_cw >= SUM_W'(du))
                begin
                    h_next = CNT_W'(1);
                    k_next = '0;
                end
            end
            ST_GW_CK:
            begin
                if (jn)
                    w_next = w_reg + 1'b1;
                else
                begin
                    h_next = CNT_W'(1);
                    k_next = '0;
                end
            end
            ST_GH_RD:
            begin
                m_raddr = {sum_rh[DIM_W-1:0], sum_ck[DIM_W-1:0]};
                if (sum_rh >= SUM_W'(dv))
                begin
                    l_next = '0;
                    k_next = '0;
                end
            end
            ST_GH_CK:
            begin
                if (!jn)
                begin
                    l_next = '0;
                    k_next = '0;
                end
                else if (k_reg + 1'b1 == w_reg)
                begin
                    k_next = '0;
                    h_next = h_reg + 1'b1;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            ST_ZAP:
            begin
                m_we    = 1'b1;
                m_waddr = {sum_rl[DIM_W-1:0], sum_ck[DIM_W-1:0]};
                m_wdata = '0;
                if (k_reg + 1'b1 == w_reg)
                begin
                    k_next = '0;
                    l_next = l_reg + 1'b1;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            ST_NEXT:
            begin
                cur_r_next = '0;
                cur_c_next = '0;
                if (wrap)
                begin
                    slice_next = '0;
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = 2'd0;
                        phase_next = PH_DONE;
                    end
                    else
                        axis_next = axis_reg + 1'b1;
                end
                else
                    slice_next = SLICE_W'(slice_inc);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    if (phase_reg == PH_SCAN)
                    begin
                        res_next.quad_valid  = 1'b1;
                        res_next.quad_colour = colour_reg;
                        res_next.face_dir    = {axis_reg, facing_reg};
                        res_next.extent_u    = 6'(w_reg);
                        res_next.extent_v    = 6'(h_reg);
                        unique case (axis_reg)
                            2'd0:
                            begin
                                res_next.base_x = 6'(slice_reg);
                                res_next.base_y = 6'(cur_c_reg);
                                res_next.base_z = 6'(cur_r_reg);
                            end
                            2'd1:
                            begin
                                res_next.base_y = 6'(slice_reg);
                                res_next.base_z = 6'(cur_c_reg);
                                res_next.base_x = 6'(cur_r_reg);
                            end
                            default:
                            begin
                                res_next.base_z = 6'(slice_reg);
                                res_next.base_x = 6'(cur_c_reg);
                                res_next.base_y = 6'(cur_r_reg);
                            end
                        endcase
                        cur_c_next = CNT_W'(sum_cw);
                    end
                    else
                        res_next.sweep_done = 1'b1;
                end
            end
            default: ;
        endcase

        // Register writes restart the sweep.
        if (cfg_hit)
        begin
            phase_next = PH_IDLE;
            unique case (cfg_index)
                REG_SIZE_X: size_x_next = cfg_data;
                REG_SIZE_Y: size_y_next = cfg_data;
                REG_SIZE_Z: size_z_next = cfg_data;
                default:    merge_next  = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_IDLE;
            axis_reg      <= '0;
            slice_reg     <= '0;
            cur_r_reg     <= '0;
            cur_c_reg     <= '0;
            clr_addr_reg  <= '0;
            size_x_reg    <= CFG_DATA_W'(MAX_DIM);
            size_y_reg    <= CFG_DATA_W'(MAX_DIM);
            size_z_reg    <= CFG_DATA_W'(MAX_DIM);
            merge_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            axis_reg      <= axis_next;
            slice_reg     <= slice_next;
            cur_r_reg     <= cur_r_next;
            cur_c_reg     <= cur_c_next;
            clr_addr_reg  <= clr_addr_next;
            size_x_reg    <= size_x_next;
            size_y_reg    <= size_y_next;
            size_z_reg    <= size_z_next;
            merge_reg     <= merge_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        l_reg      <= l_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        colour_reg <= colour_next;
        facing_reg <= facing_next;
        a_reg      <= a_next;
        res_reg    <= res_next;
    end

    // Voxel store: single port, registered read.
    always_ff @(posedge clk)
    begin
        if (vox_we)
            vox_mem[vox_addr] <= vox_wdata;
        else
            vox_rdata_reg <= vox_mem[vox_addr];
    end

    // Face mask: {facing, colour}, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (m_we)
            mask_mem[m_waddr] <= m_wdata;
        m_rdata_reg <= mask_mem[m_raddr];
    end

endmodule

// ===== design/greedy_voxel_face_mesher_core.sv =====
// Top level of the greedy voxel face mesher: front queue plus back sequencer.
// Depends on gvfm_pkg, gvfm_front and gvfm_back.
//
// Write items (op 0) store one palette byte in a 32x32x32 voxel store; pull items
// (op 1) return the next merged boundary quad, or a done result once the sweep is
// exhausted. Any voxel write or register write restarts the sweep. After reset
// the voxel store is swept to zero, one entry per cycle; items are not taken
// while it is cleared, config writes are. A pull is paced by the single
// voxel-store read port and the face-mask read port: building each slice mask
// reads two voxels and writes one mask entry per in-plane cell, scanning reads
// and checks each mask cell in turn, growing a rectangle reads and tests each
// cell in turn, clearing writes each covered cell to zero, and the result then
// goes into the result register. A pull that crosses to a new slice also builds
// that slice's mask first. A two-entry command queue keeps accepting items,
// until it is full, while the back end works or a result waits to be taken.
// Config writes (index 0..3: size_x, size_y, size_z, merge_colours) are always
// ready and belong to idle periods only.
module greedy_voxel_face_mesher_core
    import gvfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    status_t status;

    // Front: classify incoming transactions and queue them.
    gvfm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .status     (status),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // Back: storage, mask build, rectangle growth and result register.
    gvfm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== design/gvfm_checker.sv =====
// Port-level checker for the mesher top level, attached by bind.
// Depends on gvfm_pkg and greedy_voxel_face_mesher_core_macros.svh.
`include "greedy_voxel_face_mesher_core_macros.svh"

module gvfm_port_checker
    import gvfm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  result_valid,
    input logic                  result_ready,
    input result_t               result,
    input logic                  cfg_ready
);

    `GVFM_CHECK(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")

    `GVFM_CHECK(a_cfg_ready, cfg_ready, "config port not ready")

    `GVFM_CHECK(a_quad_shape, result_valid && result.quad_valid |-> !result.sweep_done && result.extent_u != 6'd0 && result.extent_v != 6'd0 && result.quad_colour != 8'd0, "malformed quad")

    `GVFM_CHECK(a_done_clean, result_valid && result.sweep_done |-> !result.quad_valid && result.extent_u == 6'd0 && result.extent_v == 6'd0, "malformed done result")

endmodule

bind greedy_voxel_face_mesher_core gvfm_port_checker u_gvfm_checker (.*);
